// ===== hdl/abst_pkg.sv =====
`default_nettype none

package abst_pkg;

    // Operation codes of the request beat.
    localparam logic [1:0] FUNC_INSERT = 2'd0;
    localparam logic [1:0] FUNC_DELETE = 2'd1;
    localparam logic [1:0] FUNC_FIND   = 2'd2;

    // Status codes of the response beat.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    // Step addresses of the control program.
    localparam int STEP_W = 5;
    typedef logic [STEP_W-1:0] step_t;

    localparam step_t S_INS0 = 5'd0;
    localparam step_t S_INS1 = 5'd1;
    localparam step_t S_INS2 = 5'd2;
    localparam step_t S_INSW = 5'd3;
    localparam step_t S_OVF  = 5'd4;
    localparam step_t S_FND0 = 5'd5;
    localparam step_t S_FND1 = 5'd6;
    localparam step_t S_FND2 = 5'd7;
    localparam step_t S_FND3 = 5'd8;
    localparam step_t S_HIT  = 5'd9;
    localparam step_t S_RML0 = 5'd10;
    localparam step_t S_RML1 = 5'd11;
    localparam step_t S_RML2 = 5'd12;
    localparam step_t S_RMR0 = 5'd13;
    localparam step_t S_RMR1 = 5'd14;
    localparam step_t S_RMR2 = 5'd15;
    localparam step_t S_WK0  = 5'd16;
    localparam step_t S_WK1  = 5'd17;
    localparam step_t S_WK2  = 5'd18;
    localparam step_t S_MOVE = 5'd19;
    localparam step_t S_CLR  = 5'd20;
    localparam step_t S_NF   = 5'd21;
    localparam step_t S_OKD  = 5'd22;

    // Which slot address a step reads from the node memory.
    typedef enum logic [2:0] {
        PR_NONE,
        PR_IDX,
        PR_IDX_L,
        PR_IDX_R,
        PR_J_DIR
    } probe_t;

    // Jump condition of a step.
    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_OOR,
        C_MISS,
        C_MATCH,
        C_FIND
    } cond_t;

    // Datapath action of a step.
    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_WALK_INS,
        ACT_WALK_FIND,
        ACT_WRITE_KEY,
        ACT_TAKE_J,
        ACT_MOVE,
        ACT_CLEAR,
        ACT_HIT
    } act_t;

    // Direction of the chain walk during a delete.
    typedef enum logic [1:0] {
        DIR_KEEP,
        DIR_LEFT,
        DIR_RIGHT
    } dir_t;

    // One control word.
    typedef struct packed {
        probe_t probe;
        cond_t  cond;
        step_t  target;
        act_t   act;
        dir_t   dir;
        logic   done;
        logic [1:0] status;
    } uword_t;

    // Datapath flags that the jump conditions test.
    typedef struct packed {
        logic oor;
        logic miss;
        logic match;
        logic find;
    } seq_flags_t;

    function automatic uword_t uw_make(
        input probe_t     probe,
        input cond_t      cond,
        input step_t      target,
        input act_t       act,
        input dir_t       dir,
        input logic       done,
        input logic [1:0] status
    );
        uword_t w;
        w.probe  = probe;
        w.cond   = cond;
        w.target = target;
        w.act    = act;
        w.dir    = dir;
        w.done   = done;
        w.status = status;
        return w;
    endfunction

    // The control program.
    function automatic uword_t ucode(input step_t step);
        uword_t w;
        w = '0;
        unique case (step)
            // Insert: walk down, left on key <= node, write the first empty slot.
            S_INS0: w = uw_make(PR_IDX, C_OOR, S_OVF, ACT_NONE, DIR_KEEP, 1'b0, ST_OK);
            S_INS1: w = uw_make(PR_NONE, C_MISS, S_INSW, ACT_NONE, DIR_KEEP, 1'b0, ST_OK);
            S_INS2: w = uw_make(PR_NONE, C_ALWAYS, S_INS0, ACT_WALK_INS, DIR_KEEP, 1'b0,
                                ST_OK);
            S_INSW: w = uw_make(PR_NONE, C_ALWAYS, S_OKD, ACT_WRITE_KEY, DIR_KEEP, 1'b0,
                                ST_OK);
            S_OVF:  w = uw_make(PR_NONE, C_NEVER, S_INS0, ACT_NONE, DIR_KEEP, 1'b1,
                                ST_OVERFLOW);
            // Find, shared by delete: stop at the first match.
            S_FND0: w = uw_make(PR_IDX, C_OOR, S_NF, ACT_NONE, DIR_KEEP, 1'b0, ST_OK);
            S_FND1: w = uw_make(PR_NONE, C_MISS, S_NF, ACT_NONE, DIR_KEEP, 1'b0, ST_OK);
            S_FND2: w = uw_make(PR_NONE, C_MATCH, S_HIT, ACT_NONE, DIR_KEEP, 1'b0, ST_OK);
            S_FND3: w = uw_make(PR_NONE, C_ALWAYS, S_FND0, ACT_WALK_FIND, DIR_KEEP, 1'b0,
                                ST_OK);
            S_HIT:  w = uw_make(PR_NONE, C_FIND, S_OKD, ACT_HIT, DIR_KEEP, 1'b0, ST_OK);
            // Delete: take the predecessor when a left child exists.
            S_RML0: w = uw_make(PR_IDX_L, C_OOR, S_RMR0, ACT_NONE, DIR_KEEP, 1'b0, ST_OK);
            S_RML1: w = uw_make(PR_NONE, C_MISS, S_RMR0, ACT_NONE, DIR_KEEP, 1'b0, ST_OK);
            S_RML2: w = uw_make(PR_NONE, C_ALWAYS, S_WK0, ACT_TAKE_J, DIR_RIGHT, 1'b0,
                                ST_OK);
            // Otherwise take the successor, or clear a leaf.
            S_RMR0: w = uw_make(PR_IDX_R, C_OOR, S_CLR, ACT_NONE, DIR_KEEP, 1'b0, ST_OK);
            S_RMR1: w = uw_make(PR_NONE, C_MISS, S_CLR, ACT_NONE, DIR_KEEP, 1'b0, ST_OK);
            S_RMR2: w = uw_make(PR_NONE, C_ALWAYS, S_WK0, ACT_TAKE_J, DIR_LEFT, 1'b0,
                                ST_OK);
            // Follow the chain to the extreme node of the subtree.
            S_WK0:  w = uw_make(PR_J_DIR, C_OOR, S_MOVE, ACT_NONE, DIR_KEEP, 1'b0, ST_OK);
            S_WK1:  w = uw_make(PR_NONE, C_MISS, S_MOVE, ACT_NONE, DIR_KEEP, 1'b0, ST_OK);
            S_WK2:  w = uw_make(PR_NONE, C_ALWAYS, S_WK0, ACT_TAKE_J, DIR_KEEP, 1'b0,
                                ST_OK);
            S_MOVE: w = uw_make(PR_NONE, C_ALWAYS, S_RML0, ACT_MOVE, DIR_KEEP, 1'b0,
                                ST_OK);
            S_CLR:  w = uw_make(PR_NONE, C_NEVER, S_INS0, ACT_CLEAR, DIR_KEEP, 1'b1, ST_OK);
            // Terminal steps.
            S_NF:   w = uw_make(PR_NONE, C_NEVER, S_INS0, ACT_NONE, DIR_KEEP, 1'b1,
                                ST_NOTFOUND);
            S_OKD:  w = uw_make(PR_NONE, C_NEVER, S_INS0, ACT_NONE, DIR_KEEP, 1'b1, ST_OK);
            default: w = '0;
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/abst_if.sv =====
`default_nettype none

// Request channel: operation and key.
interface abst_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         func;
    logic signed [31:0] key;

    modport source (output valid, output func, output key, input ready);
    modport sink   (input valid, input func, input key, output ready);
endinterface

// Response channel: slot and status.
interface abst_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] slot;
    logic [1:0] status;

    modport source (output valid, output slot, output status, input ready);
    modport sink   (input valid, input slot, input status, output ready);
endinterface

`default_nettype wire

// ===== hdl/array_binary_search_tree.sv =====
`default_nettype none

// Channel  Dir  Beat fields         Meaning
// req      in   func[1:0], key[31:0] insert, delete or find one signed key
// rsp      out  slot[7:0], status[1:0] slot touched, or status not ok
//
// A microcoded sequencer works one request at a time, one step per cycle but for a held last
// step. Insert walks occupied levels down to the first empty slot, or reports overflow. Find
// walks down to a hit or a miss. Delete runs the find to its hit, then moves the nearest key
// of a child subtree up until it clears a leaf. rsp.valid and req.ready rise together after
// the last step. Reset clears all 2**TREE_LEVELS - 1 slots, req.ready low. The response
// register frees the sequencer; a stalled full one holds the next request at its last step.
module array_binary_search_tree #(
    parameter int TREE_LEVELS = 8
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    abst_req_if.sink   req,
    abst_rsp_if.source rsp
);

    import abst_pkg::*;

    localparam int AW    = TREE_LEVELS;
    localparam int PW    = TREE_LEVELS + 1;
    localparam int DEPTH = (2 ** TREE_LEVELS) - 1;
    localparam int MW    = 33;

    localparam logic [PW-1:0] NSLOTS    = PW'(DEPTH);
    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

    // Datapath registers.
    logic [PW-1:0]      idx_reg;
    logic [PW-1:0]      j_reg;
    logic [PW-1:0]      probe_reg;
    logic signed [31:0] key_reg;
    logic [31:0]        val_reg;
    logic [1:0]         func_reg;
    logic [7:0]         slot_reg;
    logic               dir_reg;

    // Clearing pass and response registers.
    logic               clr_busy_reg;
    logic [AW-1:0]      clr_cnt_reg;
    logic               out_valid_reg;
    logic [7:0]         out_slot_reg;
    logic [1:0]         out_status_reg;

    // Sequencer links.
    uword_t     uw;
    seq_flags_t flags;
    logic       active;
    logic       start;
    logic       hold;
    step_t      start_step;

    // Memory ports.
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [MW-1:0]      mem_wdata;
    logic               mem_re;
    logic [MW-1:0]      mem_rdata;
    logic               rd_valid;
    logic signed [31:0] rd_value;

    // Address and child computation.
    logic [PW-1:0]      probe_addr;
    logic [PW-1:0]      idx_left;
    logic [PW-1:0]      idx_right;
    logic [PW-1:0]      j_child;
    logic [PW+7:0]      idx_ext;

    assign idx_left  = {idx_reg[PW-2:0], 1'b0} + PW'(1);
    assign idx_right = {idx_reg[PW-2:0], 1'b0} + PW'(2);
    assign j_child   = {j_reg[PW-2:0], 1'b0} + (dir_reg ? PW'(2) : PW'(1));
    assign idx_ext   = {8'b0, idx_reg};

    always_comb
    begin
        unique case (uw.probe)
            PR_IDX:   probe_addr = idx_reg;
            PR_IDX_L: probe_addr = idx_left;
            PR_IDX_R: probe_addr = idx_right;
            PR_J_DIR: probe_addr = j_child;
            default:  probe_addr = idx_reg;
        endcase
    end

    assign rd_valid = mem_rdata[32];
    assign rd_value = $signed(mem_rdata[31:0]);

    // Flags tested by the control program.
    assign flags.oor   = (probe_addr >= NSLOTS);
    assign flags.miss  = !rd_valid;
    assign flags.match = (rd_value == key_reg);
    assign flags.find  = (func_reg == FUNC_FIND);

    // Request handshake and program entry.
    assign req.ready = !clr_busy_reg && !active;
    assign start     = req.valid && req.ready;
    assign hold      = out_valid_reg && !rsp.ready;

    always_comb
    begin
        unique case (req.func)
            FUNC_INSERT: start_step = S_INS0;
            FUNC_DELETE: start_step = S_FND0;
            FUNC_FIND:   start_step = S_FND0;
            default:     start_step = S_NF;
        endcase
    end

    abst_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .start_step (start_step),
        .flags      (flags),
        .hold       (hold),
        .uw         (uw),
        .active     (active)
    );

    // Memory read: at most one probe per step, only at slots that exist.
    assign mem_re = (uw.probe != PR_NONE) && !flags.oor;

    // Memory write: clearing pass, or an insert, move or clear.
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = idx_reg[AW-1:0];
        mem_wdata = {1'b1, key_reg};
        if (clr_busy_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_reg;
            mem_wdata = '0;
        end
        else
        begin
            case (uw.act)
                ACT_WRITE_KEY:
                begin
                    mem_we    = 1'b1;
                    mem_wdata = {1'b1, key_reg};
                end
                ACT_MOVE:
                begin
                    mem_we    = 1'b1;
                    mem_wdata = {1'b1, val_reg};
                end
                ACT_CLEAR:
                begin
                    mem_we    = 1'b1;
                    mem_wdata = '0;
                end
                default:
                begin
                    mem_we = 1'b0;
                end
            endcase
        end
    end

    abst_ram #(
        .WIDTH (MW),
        .DEPTH (DEPTH)
    ) u_node_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (probe_addr[AW-1:0]),
        .rdata (mem_rdata)
    );

    // Clearing pass after reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end
        else if (clr_busy_reg)
        begin
            if (clr_cnt_reg == LAST_SLOT)
            begin
                clr_busy_reg <= 1'b0;
            end
            clr_cnt_reg <= clr_cnt_reg + AW'(1);
        end
    end

    // Datapath actions under the control word.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            key_reg  <= req.key;
            func_reg <= req.func;
            idx_reg  <= '0;
        end
        else
        begin
            if (uw.probe != PR_NONE)
            begin
                probe_reg <= probe_addr;
            end
            case (uw.dir)
                DIR_LEFT:  dir_reg <= 1'b0;
                DIR_RIGHT: dir_reg <= 1'b1;
                default:   dir_reg <= dir_reg;
            endcase
            case (uw.act)
                ACT_WALK_INS:
                begin
                    idx_reg <= (rd_value < key_reg) ? idx_right : idx_left;
                end
                ACT_WALK_FIND:
                begin
                    idx_reg <= (key_reg < rd_value) ? idx_left : idx_right;
                end
                ACT_WRITE_KEY, ACT_HIT:
                begin
                    slot_reg <= idx_ext[7:0];
                end
                ACT_TAKE_J:
                begin
                    j_reg   <= probe_reg;
                    val_reg <= mem_rdata[31:0];
                end
                ACT_MOVE:
                begin
                    idx_reg <= j_reg;
                end
                default:
                begin
                    idx_reg <= idx_reg;
                end
            endcase
        end
    end

    // Response register: loaded at a terminal step, freed by the sink.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (uw.done && !hold)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (uw.done && !hold)
        begin
            out_slot_reg   <= (uw.status == ST_OK) ? slot_reg : 8'd0;
            out_status_reg <= uw.status;
        end
    end

    assign rsp.valid  = out_valid_reg;
    assign rsp.slot   = out_slot_reg;
    assign rsp.status = out_status_reg;

endmodule

`default_nettype wire

// ===== hdl/abst_ram.sv =====
`default_nettype none

// Simple dual-port RAM: one write port, one read port with registered data.
module abst_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 255
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== hdl/abst_seq.sv =====
`default_nettype none

// Step counter and control store: issues one control word per cycle.
module abst_seq (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire abst_pkg::step_t     start_step,
    input  wire abst_pkg::seq_flags_t flags,
    input  wire logic                hold,
    output abst_pkg::uword_t         uw,
    output logic                     active
);

    import abst_pkg::*;

    step_t upc_reg;
    logic  run_reg;
    logic  jump;

    // Control word of the current step; all-zero is a no-op while idle.
    assign uw     = run_reg ? ucode(upc_reg) : '0;
    assign active = run_reg;

    // Jump condition select.
    always_comb
    begin
        unique case (uw.cond)
            C_NEVER:  jump = 1'b0;
            C_ALWAYS: jump = 1'b1;
            C_OOR:    jump = flags.oor;
            C_MISS:   jump = flags.miss;
            C_MATCH:  jump = flags.match;
            C_FIND:   jump = flags.find;
            default:  jump = 1'b0;
        endcase
    end

    // Step counter: start, advance, jump, or stop at a terminal step.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            upc_reg <= S_INS0;
        end
        else if (start)
        begin
            run_reg <= 1'b1;
            upc_reg <= start_step;
        end
        else if (run_reg)
        begin
            if (uw.done)
            begin
                if (!hold)
                begin
                    run_reg <= 1'b0;
                end
            end
            else if (jump)
            begin
                upc_reg <= uw.target;
            end
            else
            begin
                upc_reg <= upc_reg + STEP_W'(1);
            end
        end
    end

endmodule

`default_nettype wire
